[rtl/core/lmat_pkg.sv]
package lmat_pkg;

    // result pipeline from input transaction to fifo push
    localparam int LAT = 6;

    // result fifo, one entry per input transaction that yields results
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W    = FIFO_AW + 1;
    localparam int INFL_W     = $clog2(LAT + 1);
    localparam int CLAIM_W    = LEVEL_W + 1;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 13;
    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_CONTRAST_OFFSET = 2'd2;

    localparam int RST_IMAGE_WIDTH     = 640;
    localparam int RST_IMAGE_HEIGHT    = 480;
    localparam int RST_CONTRAST_OFFSET = 65;
    localparam int MIN_SIZE            = 3;

    // reciprocal multipliers: x/9 = (x*3641)>>15 for x < 32768,
    // x/3 = (x*43691)>>17 for x < 131072
    localparam logic [23:0] DIV9_MUL = 24'd3641;
    localparam logic [26:0] DIV3_MUL = 27'd43691;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [11:0] out_row;
        logic [10:0] out_col;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic        is_decision;
        logic        last;
    } result_t;

    // per-channel sum of one window column
    typedef struct packed {
        logic [9:0] red;
        logic [9:0] green;
        logic [9:0] blue;
    } col_sum_t;

    typedef struct packed {
        col_sum_t left;
        col_sum_t mid_col;
        col_sum_t right;
        in_item_t ctr_px;
    } window_t;

    typedef struct packed {
        logic [11:0] row;
        logic [10:0] col;
        in_item_t    px;
        logic        has_dec;
        logic        has_bdr;
        logic        white;
    } entry_t;

    function automatic logic [7:0] div9(input logic [11:0] x);
        logic [23:0] p;
        p = 24'(x) * DIV9_MUL;
        return p[22:15];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [26:0] p;
        p = 27'(x) * DIV3_MUL;
        return p[24:17];
    endfunction

endpackage

[rtl/core/lmat_window.sv]
module lmat_window import lmat_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int CW        = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic [CW-1:0] in_col,
    input  in_item_t      in_px,
    output window_t       win
);

    // line store: upper line in [47:24], middle line in [23:0]
    logic [47:0] line_mem [MAX_WIDTH];

    logic [47:0]   rd_reg;
    logic [47:0]   fwd_data_reg;
    logic          fwd_reg;
    logic          v1_reg;
    logic [CW-1:0] col1_reg;
    in_item_t      px1_reg;

    col_sum_t left_reg;
    col_sum_t mid_col_reg;
    col_sum_t right_reg;
    in_item_t mid_prev_reg;
    in_item_t ctr_reg;

    logic [47:0] rd_data;
    in_item_t    up;
    in_item_t    mid;
    logic [47:0] wr_data;
    col_sum_t    new_sum;

    assign rd_data = fwd_reg ? fwd_data_reg : rd_reg;
    assign up      = rd_data[47:24];
    assign mid     = rd_data[23:0];
    assign wr_data = {mid, px1_reg};

    assign new_sum.red   = 10'(up.red) + 10'(mid.red) + 10'(px1_reg.red);
    assign new_sum.green = 10'(up.green) + 10'(mid.green) + 10'(px1_reg.green);
    assign new_sum.blue  = 10'(up.blue) + 10'(mid.blue) + 10'(px1_reg.blue);

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            rd_reg <= line_mem[in_col];
        end
        if (v1_reg) begin
            line_mem[col1_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            if (in_valid) begin
                // same column still being written back
                fwd_reg <= v1_reg && (col1_reg == in_col);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            col1_reg     <= in_col;
            px1_reg      <= in_px;
            fwd_data_reg <= wr_data;
        end
        if (v1_reg) begin
            left_reg     <= mid_col_reg;
            mid_col_reg  <= right_reg;
            right_reg    <= new_sum;
            ctr_reg      <= mid_prev_reg;
            mid_prev_reg <= mid;
        end
    end

    assign win.left    = left_reg;
    assign win.mid_col = mid_col_reg;
    assign win.right   = right_reg;
    assign win.ctr_px  = ctr_reg;

endmodule

[rtl/core/lmat_decide.sv]
module lmat_decide import lmat_pkg::*; (
    input  logic       aclk,
    input  window_t    win,
    input  logic [7:0] offset,
    output logic       white
);

    logic [11:0] tot_r_reg, tot_g_reg, tot_b_reg;
    logic [9:0]  ctr_sum_reg;
    logic [7:0]  avg_r_reg, avg_g_reg, avg_b_reg;
    logic [7:0]  ctr_b_reg;
    logic [9:0]  mean_sum_reg;
    logic [7:0]  ctr_c_reg;
    logic        white_reg;
    logic [7:0]  mean;

    assign mean = div3(mean_sum_reg);

    always_ff @(posedge aclk) begin
        // 3x3 channel sums and center brightness sum
        tot_r_reg   <= 12'(win.left.red) + 12'(win.mid_col.red) + 12'(win.right.red);
        tot_g_reg   <= 12'(win.left.green) + 12'(win.mid_col.green)
                       + 12'(win.right.green);
        tot_b_reg   <= 12'(win.left.blue) + 12'(win.mid_col.blue) + 12'(win.right.blue);
        ctr_sum_reg <= 10'(win.ctr_px.red) + 10'(win.ctr_px.green)
                       + 10'(win.ctr_px.blue);
        // channel averages
        avg_r_reg   <= div9(tot_r_reg);
        avg_g_reg   <= div9(tot_g_reg);
        avg_b_reg   <= div9(tot_b_reg);
        ctr_b_reg   <= div3(ctr_sum_reg);
        // local mean numerator
        mean_sum_reg <= 10'(avg_r_reg) + 10'(avg_g_reg) + 10'(avg_b_reg);
        ctr_c_reg    <= ctr_b_reg;
        // center - mean > offset
        white_reg <= {1'b0, ctr_c_reg} > ({1'b0, mean} + {1'b0, offset});
    end

    assign white = white_reg;

endmodule

[rtl/core/lmat_out.sv]
module lmat_out import lmat_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  entry_t             push_entry,
    output logic [LEVEL_W-1:0] level,
    output logic               m_valid,
    input  logic               m_ready,
    output result_t            m_data
);

    entry_t fifo_mem [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               phase_reg, phase_next;
    logic               m_valid_reg;
    result_t            m_data_reg, m_data_next;

    entry_t head;
    logic   load;
    logic   dec_first;
    logic   pop;

    assign head      = fifo_mem[rd_ptr_reg];
    assign load      = (level_reg != '0) && (!m_valid_reg || m_ready);
    assign dec_first = head.has_dec && !phase_reg;
    assign pop       = load && !(dec_first && head.has_bdr);

    always_comb begin
        phase_next = phase_reg;
        if (dec_first) begin
            m_data_next.out_row     = head.row - 12'd1;
            m_data_next.out_col     = head.col - 11'd1;
            m_data_next.out_red     = head.white ? 8'hFF : 8'h00;
            m_data_next.out_green   = head.white ? 8'hFF : 8'h00;
            m_data_next.out_blue    = head.white ? 8'hFF : 8'h00;
            m_data_next.is_decision = 1'b1;
            m_data_next.last        = !head.has_bdr;
        end else begin
            m_data_next.out_row     = head.row;
            m_data_next.out_col     = head.col;
            m_data_next.out_red     = head.px.red;
            m_data_next.out_green   = head.px.green;
            m_data_next.out_blue    = head.px.blue;
            m_data_next.is_decision = 1'b0;
            m_data_next.last        = 1'b1;
        end
        if (load) begin
            phase_next = !pop;
        end
    end

    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + LEVEL_W'(1);
        end else if (!push && pop) begin
            level_next = level_reg - LEVEL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_entry;
        end
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            level_reg   <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            level_reg <= level_next;
            phase_reg <= phase_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign level   = level_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (level_reg < LEVEL_W'(FIFO_DEPTH)))
        else $error("result fifo written while full");

    a_phase_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> ((level_reg != '0) && head.has_dec && head.has_bdr))
        else $error("second half pending on an entry without two results");
`endif

endmodule

[rtl/core/local_mean_adaptive_threshold.sv]
// 3x3 local-mean adaptive threshold on an rgb raster stream. pixels enter one
// per transaction, row after row; the frame size comes from image_width and
// image_height (clamped to 3..MAX_WIDTH / 3..MAX_HEIGHT), and writing either
// one restarts the frame at row 0, column 0. every interior pixel comes out
// as one decision result (white when its brightness exceeds the 3x3 mean by
// more than contrast_offset, black otherwise) and every border pixel comes out
// unchanged; each result carries its row and column and a last flag marking
// the final result of the input transaction that caused it. the input takes
// one pixel per clock, one transaction per cycle, set by the simple dual-port
// read-modify-write of the line store (one read and one write each cycle).
// results leave at one per clock, so a pixel that yields two results (last
// column from row 2 on, last row from column 2 on) holds the output for
// both of them; a 16-entry result fifo absorbs that and any output stall,
// and the input pauses only when the fifo plus the in-flight items fill it.
// the line store is not cleared after reset; it is fully written by the
// first two rows of a frame, so no clearing pass is needed.
module local_mean_adaptive_threshold import lmat_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration writes
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    // pixel input
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output result_t           m_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // reset frame size after clamping to the supported range
    localparam int RST_W_EFF = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H_EFF = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : RST_IMAGE_HEIGHT;
    localparam logic [CW-1:0] RST_LAST_COL = CW'(RST_W_EFF - 1);
    localparam logic [RW-1:0] RST_LAST_ROW = RW'(RST_H_EFF - 1);

    // frame geometry held as last column / last row indices
    logic [CW-1:0] last_col_reg, last_col_wr;
    logic [RW-1:0] last_row_reg, last_row_wr;
    logic [7:0]    offset_reg;

    // raster position of the next input pixel
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic     accept;
    logic     has_dec;
    logic     has_bdr;
    entry_t   s0_entry;

    // result metadata travels beside the decision datapath
    entry_t         meta_reg [LAT];
    logic [LAT-1:0] mv_reg;
    entry_t         push_entry;

    logic [INFL_W-1:0]  inflight;
    logic [LEVEL_W-1:0] level;
    logic [CLAIM_W-1:0] claims;

    window_t win;
    logic    white;

    // ---------------------------------------------------------------
    // configuration: clamp the written size into range at write time
    // ---------------------------------------------------------------
    always_comb begin
        if (cfg_wdata[11:0] < 12'(MIN_SIZE)) begin
            last_col_wr = CW'(MIN_SIZE - 1);
        end else if ({20'd0, cfg_wdata[11:0]} > 32'(MAX_WIDTH)) begin
            last_col_wr = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_wr = CW'(cfg_wdata[11:0] - 12'd1);
        end
    end

    always_comb begin
        if (cfg_wdata < 13'(MIN_SIZE)) begin
            last_row_wr = RW'(MIN_SIZE - 1);
        end else if ({19'd0, cfg_wdata} > 32'(MAX_HEIGHT)) begin
            last_row_wr = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row_wr = RW'(cfg_wdata - 13'd1);
        end
    end

    // ---------------------------------------------------------------
    // raster counters and per-pixel result flags
    // ---------------------------------------------------------------
    assign accept = s_valid && s_ready;

    always_comb begin
        row_next = row_reg;
        if (col_reg == last_col_reg) begin
            col_next = '0;
            row_next = (row_reg == last_row_reg) ? '0 : row_reg + RW'(1);
        end else begin
            col_next = col_reg + CW'(1);
        end
    end

    // decision for (row-1, col-1) once a full 3x3 window is in
    assign has_dec = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    // this pixel itself on the frame border
    assign has_bdr = (row_reg == '0) || (row_reg == last_row_reg)
                     || (col_reg == '0) || (col_reg == last_col_reg);

    assign s0_entry.row     = 12'(row_reg);
    assign s0_entry.col     = 11'(col_reg);
    assign s0_entry.px      = s_data;
    assign s0_entry.has_dec = has_dec;
    assign s0_entry.has_bdr = has_bdr;
    assign s0_entry.white   = 1'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= RST_LAST_COL;
            last_row_reg <= RST_LAST_ROW;
            offset_reg   <= 8'(RST_CONTRAST_OFFSET);
            col_reg      <= '0;
            row_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH: begin
                    last_col_reg <= last_col_wr;
                    col_reg      <= '0;
                    row_reg      <= '0;
                end
                REG_IMAGE_HEIGHT: begin
                    last_row_reg <= last_row_wr;
                    col_reg      <= '0;
                    row_reg      <= '0;
                end
                REG_CONTRAST_OFFSET: begin
                    offset_reg <= cfg_wdata[7:0];
                end
                default: begin
                    // unused index, write ignored
                end
            endcase
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // line store and window, then the threshold datapath
    // ---------------------------------------------------------------
    lmat_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_col   (col_reg),
        .in_px    (s_data),
        .win      (win)
    );

    lmat_decide u_decide (
        .aclk   (aclk),
        .win    (win),
        .offset (offset_reg),
        .white  (white)
    );

    // ---------------------------------------------------------------
    // metadata line, aligned with the decision latency
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        meta_reg[0] <= s0_entry;
        for (int i = 1; i < LAT; i++) begin
            meta_reg[i] <= meta_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= '0;
        end else begin
            // only pixels that yield a result take a fifo slot
            mv_reg <= {mv_reg[LAT-2:0], accept && (has_dec || has_bdr)};
        end
    end

    always_comb begin
        push_entry       = meta_reg[LAT-1];
        push_entry.white = white;
    end

    // ---------------------------------------------------------------
    // result fifo and output serializer
    // ---------------------------------------------------------------
    lmat_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (mv_reg[LAT-1]),
        .push_entry (push_entry),
        .level      (level),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // accept only while every in-flight result still has a fifo slot
    assign inflight = INFL_W'($countones(mv_reg));
    assign claims   = CLAIM_W'(level) + CLAIM_W'(inflight);
    assign s_ready  = claims < CLAIM_W'(FIFO_DEPTH);

`ifndef SYNTHESIS
    a_claims_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        claims <= CLAIM_W'(FIFO_DEPTH))
        else $error("in-flight results exceed fifo space");

    a_border_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_decision) |-> m_data.last)
        else $error("border result not marked last");
`endif

endmodule

[bench/testbench.sv]
module testbench;
    import lmat_pkg::*;

    // frame limits the block is built with
    localparam int unsigned LINE_MAX = 2048;
    localparam int unsigned ROWS_MAX = 4096;

    // register index that maps to nothing
    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

    // cycles to let a result-free transaction clear the pipeline
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned RANDOM_ITEMS  = 200;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr  = '0;
    logic [CFG_DW-1:0]   cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    result_t             m_data;

    // idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;

    // threshold predictor state: registers, raster position, line stores, window
    logic [11:0] reg_width;
    logic [12:0] reg_height;
    logic [7:0]  reg_offset;
    int unsigned row_pos;
    int unsigned col_pos;
    logic [23:0] upper_line  [LINE_MAX];
    logic [23:0] middle_line [LINE_MAX];
    logic [23:0] window_px   [3][3];

    // pixels expected on the result channel, oldest first
    result_t predicted_pixels [$];
    result_t oldest_prediction;

    local_mean_adaptive_threshold #(
        .MAX_WIDTH (LINE_MAX),
        .MAX_HEIGHT(ROWS_MAX)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // effective frame size as the block sees it
    function automatic int unsigned frame_width();
        return clamp_dim(reg_width, LINE_MAX);
    endfunction

    function automatic int unsigned frame_height();
        return clamp_dim(reg_height, ROWS_MAX);
    endfunction

    // advance the raster model by one pixel and queue the pixels it releases
    task automatic threshold_pixel(input in_item_t px);
        int unsigned w, h, r, c;
        int unsigned sum_r, sum_g, sum_b, mean, centre;
        logic [23:0] up, mid, pix;
        logic        white;
        result_t     found [2];
        int          n;
        w = frame_width();
        h = frame_height();
        r = row_pos;
        c = col_pos;
        if (r >= h) r = 0;
        if (c >= w) c = 0;
        pix = px;
        up  = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = pix;
        for (int k = 0; k < 3; k++) begin
            window_px[k][0] = window_px[k][1];
            window_px[k][1] = window_px[k][2];
        end
        window_px[0][2] = up;
        window_px[1][2] = mid;
        window_px[2][2] = pix;
        n = 0;
        // decision for the pixel one row up and one column left
        if (r >= 2 && c >= 2) begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int k = 0; k < 3; k++) begin
                for (int m = 0; m < 3; m++) begin
                    sum_r += 32'(window_px[k][m][23:16]);
                    sum_g += 32'(window_px[k][m][15:8]);
                    sum_b += 32'(window_px[k][m][7:0]);
                end
            end
            mean   = (sum_r / 9 + sum_g / 9 + sum_b / 9) / 3;
            centre = (32'(window_px[1][1][23:16]) + 32'(window_px[1][1][15:8]) +
                      32'(window_px[1][1][7:0])) / 3;
            white  = (int'(centre) - int'(mean)) > int'(reg_offset);
            found[n].out_row     = 12'(r - 1);
            found[n].out_col     = 11'(c - 1);
            found[n].out_red     = {8{white}};
            found[n].out_green   = {8{white}};
            found[n].out_blue    = {8{white}};
            found[n].is_decision = 1'b1;
            found[n].last        = 1'b0;
            n++;
        end
        // border pixels pass straight through
        if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
            found[n].out_row     = 12'(r);
            found[n].out_col     = 11'(c);
            found[n].out_red     = px.red;
            found[n].out_green   = px.green;
            found[n].out_blue    = px.blue;
            found[n].is_decision = 1'b0;
            found[n].last        = 1'b0;
            n++;
        end
        if (n > 0) found[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++) predicted_pixels.push_back(found[k]);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic compare_field(input string name, input logic [15:0] expected,
                                 input logic [15:0] actual);
        if (actual !== expected) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            mismatch_count++;
        end
    endtask

    // result checker: every accepted transaction against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_pixels.size() == 0) begin
                $error("unexpected result at row %0d col %0d", m_data.out_row,
                       m_data.out_col);
                mismatch_count++;
            end else begin
                oldest_prediction = predicted_pixels.pop_front();
                compare_field("out_row", 16'(oldest_prediction.out_row),
                              16'(m_data.out_row));
                compare_field("out_col", 16'(oldest_prediction.out_col),
                              16'(m_data.out_col));
                compare_field("out_red", 16'(oldest_prediction.out_red),
                              16'(m_data.out_red));
                compare_field("out_green", 16'(oldest_prediction.out_green),
                              16'(m_data.out_green));
                compare_field("out_blue", 16'(oldest_prediction.out_blue),
                              16'(m_data.out_blue));
                compare_field("is_decision", 16'(oldest_prediction.is_decision),
                              16'(m_data.is_decision));
                compare_field("last", 16'(oldest_prediction.last), 16'(m_data.last));
            end
        end
    end

    // one pixel transaction; valid is held high between back-to-back pixels
    task automatic send_pixel(input in_item_t px);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!(s_valid && s_ready));
        threshold_pixel(px);
    endtask

    // stop sending, wait for every predicted pixel, then let the pipeline settle
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (predicted_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, only issued with the block idle
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                reg_width = value[11:0];
                row_pos   = 0;
                col_pos   = 0;
            end
            REG_IMAGE_HEIGHT: begin
                reg_height = value[12:0];
                row_pos    = 0;
                col_pos    = 0;
            end
            REG_CONTRAST_OFFSET: begin
                reg_offset = value[7:0];
            end
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // pixel mix: bright spots on dark ground give white decisions
    function automatic in_item_t random_pixel();
        in_item_t    px;
        int unsigned style;
        style = $urandom_range(9);
        if (style < 2) begin
            px.red   = 8'($urandom_range(255, 192));
            px.green = 8'($urandom_range(255, 192));
            px.blue  = 8'($urandom_range(255, 192));
        end else if (style < 5) begin
            px.red   = 8'($urandom_range(48));
            px.green = 8'($urandom_range(48));
            px.blue  = 8'($urandom_range(48));
        end else if (style == 5) begin
            px.red   = {8{1'($urandom_range(1))}};
            px.green = {8{1'($urandom_range(1))}};
            px.blue  = {8{1'($urandom_range(1))}};
        end else begin
            px = in_item_t'(24'($urandom_range(24'hFFFFFF)));
        end
        return px;
    endfunction

    task automatic send_random_pixels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_pixel(random_pixel());
    endtask

    // reset geometry 640 x 480 and offset 65: the first pixels of row 0
    task automatic test_reset_geometry();
        set_idling(0, 0);
        send_random_pixels(24);
        drain_pipeline();
    endtask

    // hand-built 3x3 frames: channel extremes, white, black, offset extremes
    task automatic test_directed_frames();
        in_item_t spot [9];
        spot[0] = '{red: 8'hFF, green: 8'h00, blue: 8'hFF};
        spot[1] = '{red: 8'h00, green: 8'h00, blue: 8'h00};
        spot[2] = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
        spot[3] = '{red: 8'h00, green: 8'h00, blue: 8'h00};
        spot[4] = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
        spot[5] = '{red: 8'h00, green: 8'h00, blue: 8'h00};
        spot[6] = '{red: 8'h00, green: 8'h00, blue: 8'h00};
        spot[7] = '{red: 8'hFF, green: 8'hFF, blue: 8'h00};
        spot[8] = '{red: 8'h00, green: 8'h00, blue: 8'hFF};
        set_idling(15, 15);
        // sizes below the minimum fall back to a 3x3 frame
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        write_reg(REG_CONTRAST_OFFSET, 13'd0);
        // bright center on dark ground: white
        for (int i = 0; i < 9; i++) send_pixel(spot[i]);
        // flat white frame: difference of zero is not above zero, so black
        for (int i = 0; i < 9; i++) send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        drain_pipeline();
        // largest offset blocks every white
        write_reg(REG_CONTRAST_OFFSET, 13'd255);
        for (int i = 0; i < 9; i++) send_pixel(spot[i]);
        drain_pipeline();
    endtask

    // writes in mid-frame: unused index and offset keep position, sizes restart
    task automatic test_frame_restart();
        set_idling(0, 66);
        write_reg(REG_IMAGE_WIDTH, 13'd5);
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        write_reg(REG_CONTRAST_OFFSET, 13'd10);
        send_random_pixels(7);
        drain_pipeline();
        write_reg(REG_UNUSED, 13'h1FFF);
        send_random_pixels(6);
        drain_pipeline();
        write_reg(REG_CONTRAST_OFFSET, 13'd30);
        // finish the frame and run partway into the next one
        send_random_pixels(7 + 8);
        drain_pipeline();
        write_reg(REG_IMAGE_WIDTH, 13'd6);
        send_random_pixels(6 * 4 * 2);
        drain_pipeline();
        write_reg(REG_IMAGE_HEIGHT, 13'd5);
        send_random_pixels(3);
        drain_pipeline();
        write_reg(REG_IMAGE_HEIGHT, 13'd5);
        send_random_pixels(6 * 5 + 4);
        drain_pipeline();
    endtask

    // width register at all ones clamps to the widest line; the row wraps after it
    task automatic test_widest_line();
        set_idling(15, 15);
        write_reg(REG_IMAGE_WIDTH, 13'hFFF);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        write_reg(REG_CONTRAST_OFFSET, 13'($urandom_range(60)));
        send_random_pixels(LINE_MAX + 4);
        drain_pipeline();
    endtask

    // height register at all ones: the first rows of a tall frame, none of them last
    task automatic test_tallest_frame();
        set_idling(15, 15);
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        write_reg(REG_CONTRAST_OFFSET, 13'($urandom_range(60)));
        send_random_pixels(3 * 8);
        drain_pipeline();
    endtask

    // small random frames, mostly whole frames, some cut short by a restart
    task automatic test_random_frames();
        int unsigned sent, count, pick;
        logic [CFG_DW-1:0] value;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(66, 0);
                2: set_idling(0, 66);
                default: set_idling(15, 15);
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                drain_pipeline();
                if ($urandom_range(9) < 7) begin
                    pick = $urandom_range(19);
                    if (pick == 0) value = 13'($urandom_range(2));
                    else if (pick == 1) value = 13'($urandom_range(40, 17));
                    else value = 13'($urandom_range(12, 3));
                    write_reg(REG_IMAGE_WIDTH, value);
                    if ($urandom_range(19) == 0) value = 13'($urandom_range(2));
                    else value = 13'($urandom_range(8, 3));
                    write_reg(REG_IMAGE_HEIGHT, value);
                end
                if ($urandom_range(9) < 6) begin
                    pick = $urandom_range(9);
                    if (pick < 5) value = 13'($urandom_range(40));
                    else if (pick < 8) value = 13'($urandom_range(120, 41));
                    else value = 13'($urandom_range(255));
                    write_reg(REG_CONTRAST_OFFSET, value);
                end
                if ($urandom_range(4) == 0) begin
                    count = $urandom_range(frame_width() * frame_height(), 1);
                end else begin
                    count = frame_width() * frame_height() * $urandom_range(2, 1) +
                            $urandom_range(2 * frame_width());
                end
                send_random_pixels(count);
                sent += count;
            end
        end
        drain_pipeline();
    endtask

    initial begin
        // predictor starts from the reset state
        reg_width  = 12'(RST_IMAGE_WIDTH);
        reg_height = 13'(RST_IMAGE_HEIGHT);
        reg_offset = 8'(RST_CONTRAST_OFFSET);
        row_pos    = 0;
        col_pos    = 0;
        for (int i = 0; i < LINE_MAX; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) window_px[k][m] = '0;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_geometry();
        test_directed_frames();
        test_frame_restart();
        test_widest_line();
        test_tallest_frame();
        test_random_frames();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
